@@ rtl/mpbm_pkg.sv @@
// Shared types, operation codes and status codes of the multi-pattern byte matcher.
package mpbm_pkg;

	// Default sizes of the automaton.
	localparam int unsigned MAX_NODES_DEF     = 256;
	localparam int unsigned ALPHABET_SIZE_DEF = 256;

	// Command operations.
	localparam logic [1:0] OP_PAT_BYTE = 2'd0;
	localparam logic [1:0] OP_PAT_END  = 2'd1;
	localparam logic [1:0] OP_BUILD    = 2'd2;
	localparam logic [1:0] OP_TEXT     = 2'd3;

	// Response status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_BUILT = 2'd2;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data_byte;
		logic       last_byte;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic       legal;
		logic       string_done;
	} rsp_t;

endpackage

@@ rtl/multi_pattern_byte_matcher_core.sv @@
// Aho-Corasick byte matcher: trie load, failure link build and text scan.
//
//  channel | direction | handshake             | payload
//  cmd     | in        | cmd_valid / cmd_stall | mpbm_pkg::cmd_t
//  rsp     | out       | rsp_valid / rsp_stall | mpbm_pkg::rsp_t
//
// Each command gives exactly one response. A pattern byte reads the transition table and
// then follows or adds a child; an end of pattern marks the entry of the last node as a
// word end. A pattern byte of a dropped pattern and a text byte before a build go straight to the response.
// A text byte follows failure links until a transition is found, each a dependent
// read of the transition and node tables. A build walks every node and every symbol of
// each node: it pops a node and reads its failure link, reads the entry of each symbol,
// and for each child tries the nodes along the parent's failure chain, then queues it.
// After reset a clearing pass writes all MAX_NODES * ALPHABET_SIZE transition table
// entries, during which cmd_stall is high. A stalled response holds the block only once
// the next result is ready; one command is accepted while a response waits.
module multi_pattern_byte_matcher_core #(
	parameter int unsigned MAX_NODES     = mpbm_pkg::MAX_NODES_DEF,
	parameter int unsigned ALPHABET_SIZE = mpbm_pkg::ALPHABET_SIZE_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  mpbm_pkg::cmd_t cmd,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output mpbm_pkg::rsp_t rsp
);
	import mpbm_pkg::*;

	localparam int unsigned NW    = $clog2(MAX_NODES);
	localparam int unsigned SW    = $clog2(ALPHABET_SIZE);
	localparam int unsigned DEPTH = MAX_NODES * ALPHABET_SIZE;
	localparam int unsigned AW    = $clog2(DEPTH);

	// Sequencer states.
	localparam logic [4:0] S_CLEAR = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_PCHK  = 5'd2;
	localparam logic [4:0] S_SCHK  = 5'd3;
	localparam logic [4:0] S_SHIT  = 5'd4;
	localparam logic [4:0] S_BINIT = 5'd5;
	localparam logic [4:0] S_BPOP  = 5'd6;
	localparam logic [4:0] S_BPOPW = 5'd7;
	localparam logic [4:0] S_BPF   = 5'd8;
	localparam logic [4:0] S_BCRD  = 5'd9;
	localparam logic [4:0] S_BCCHK = 5'd10;
	localparam logic [4:0] S_BTRD  = 5'd11;
	localparam logic [4:0] S_BTCHK = 5'd12;
	localparam logic [4:0] S_BHRD  = 5'd13;
	localparam logic [4:0] S_BHW   = 5'd14;
	localparam logic [4:0] S_RESP  = 5'd15;

	// Transition table address of a node and symbol.
	function automatic logic [AW-1:0] caddr(input logic [NW-1:0] n, input logic [SW-1:0] s);
		return AW'(n) * AW'(ALPHABET_SIZE) + AW'(s);
	endfunction

	// Memories: transition table {word end of child, child}, node table {hit, fail},
	// and the breadth-first queue.
	logic [NW:0]   child_mem [DEPTH];
	logic [NW:0]   node_mem  [MAX_NODES];
	logic [NW-1:0] queue_mem [MAX_NODES];

	logic [NW:0]   child_rd;
	logic [NW:0]   node_rd;
	logic [NW-1:0] queue_rd;

	logic [AW-1:0] child_raddr, child_waddr;
	logic [NW:0]   child_wdata;
	logic          child_we;
	logic [NW-1:0] node_raddr, node_waddr;
	logic [NW:0]   node_wdata;
	logic          node_we;
	logic [NW-1:0] queue_raddr, queue_waddr, queue_wdata;
	logic          queue_we;

	// Control and data registers.
	logic [4:0]    state_q;
	logic [AW-1:0] clr_q;
	logic [NW:0]   node_cnt_q;
	logic [NW-1:0] cursor_q;
	logic [AW-1:0] last_addr_q;
	logic [AW-1:0] paddr_q;
	logic          ovf_q;
	logic [NW-1:0] scan_node_q;
	logic          match_q;
	logic          built_q;
	logic [SW-1:0] sym_q;
	logic          last_q;
	logic [NW-1:0] cur_q;
	logic [NW-1:0] c_q;
	logic          we_q;
	logic [NW-1:0] p_q;
	logic [NW-1:0] fp_q;
	logic [NW-1:0] t_q;
	logic [NW-1:0] f_q;
	logic [SW-1:0] s_q;
	logic [NW:0]   head_q;
	logic [NW:0]   tail_q;
	rsp_t          res_q;
	rsp_t          rsp_q;
	logic          rsp_valid_q;

	logic [SW-1:0] fold_lut [256];
	logic [SW-1:0] sym_in;
	logic [NW-1:0] rd_child;
	logic [NW-1:0] rd_fail;
	logic          rd_hit;
	logic          sym_last;
	logic          scan_m;

	// Reduction of a byte into the alphabet, a constant table worked out at elaboration.
	for (genvar gi = 0; gi < 256; gi++) begin : g_fold
		assign fold_lut[gi] = SW'(gi % ALPHABET_SIZE);
	end

	assign sym_in   = fold_lut[cmd.data_byte];
	assign rd_child = child_rd[NW-1:0];
	assign rd_fail  = node_rd[NW-1:0];
	assign rd_hit   = node_rd[NW];
	assign sym_last = (s_q == SW'(ALPHABET_SIZE - 1));
	assign scan_m   = match_q | rd_hit;

	assign cmd_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Memory ports, one read and one write address each.
	always_ff @(posedge clk) begin
		if (child_we) begin
			child_mem[child_waddr] <= child_wdata;
		end
		child_rd <= child_mem[child_raddr];
	end

	always_ff @(posedge clk) begin
		if (node_we) begin
			node_mem[node_waddr] <= node_wdata;
		end
		node_rd <= node_mem[node_raddr];
	end

	always_ff @(posedge clk) begin
		if (queue_we) begin
			queue_mem[queue_waddr] <= queue_wdata;
		end
		queue_rd <= queue_mem[queue_raddr];
	end

	// Memory addresses and writes for each state.
	always_comb begin
		child_raddr = '0;
		child_waddr = '0;
		child_wdata = '0;
		child_we    = 1'b0;
		node_raddr  = '0;
		node_waddr  = '0;
		node_wdata  = '0;
		node_we     = 1'b0;
		queue_raddr = '0;
		queue_waddr = '0;
		queue_wdata = '0;
		queue_we    = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				child_we    = 1'b1;
				child_waddr = clr_q;
			end
			S_IDLE: begin
				child_raddr = caddr((cmd.op == OP_TEXT) ? scan_node_q : cursor_q, sym_in);
				node_raddr  = scan_node_q;
				// End of a pattern marks the entry that leads to the cursor node.
				if (cmd_valid && cmd.op == OP_PAT_END && !ovf_q && cursor_q != '0) begin
					child_we    = 1'b1;
					child_waddr = last_addr_q;
					child_wdata = {1'b1, cursor_q};
				end
			end
			S_PCHK: begin
				if (rd_child == '0 && node_cnt_q != (NW+1)'(MAX_NODES)) begin
					child_we    = 1'b1;
					child_waddr = paddr_q;
					child_wdata = {1'b0, node_cnt_q[NW-1:0]};
				end
			end
			S_SCHK: begin
				node_raddr  = (rd_child != '0 || cur_q == '0) ? rd_child : rd_fail;
				child_raddr = caddr(rd_fail, sym_q);
			end
			S_BINIT: begin
				node_we  = 1'b1;
				queue_we = 1'b1;
			end
			S_BPOP: begin
				queue_raddr = head_q[NW-1:0];
			end
			S_BPOPW: begin
				node_raddr = queue_rd;
			end
			S_BCRD: begin
				child_raddr = caddr(p_q, s_q);
			end
			S_BTRD: begin
				child_raddr = caddr(t_q, s_q);
				node_raddr  = t_q;
			end
			S_BHRD: begin
				node_raddr = f_q;
			end
			S_BHW: begin
				node_we     = 1'b1;
				node_waddr  = c_q;
				node_wdata  = {we_q | rd_hit, f_q};
				queue_we    = 1'b1;
				queue_waddr = tail_q[NW-1:0];
				queue_wdata = c_q;
			end
			default: begin
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			node_cnt_q  <= (NW+1)'(1);
			cursor_q    <= '0;
			last_addr_q <= '0;
			paddr_q     <= '0;
			ovf_q       <= 1'b0;
			scan_node_q <= '0;
			match_q     <= 1'b0;
			built_q     <= 1'b0;
			sym_q       <= '0;
			last_q      <= 1'b0;
			cur_q       <= '0;
			c_q         <= '0;
			we_q        <= 1'b0;
			p_q         <= '0;
			fp_q        <= '0;
			t_q         <= '0;
			f_q         <= '0;
			s_q         <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// Outside the hand-over state a transferred response frees the register.
			if (rsp_valid_q && !rsp_stall && state_q != S_RESP) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_valid) begin
						sym_q  <= sym_in;
						last_q <= cmd.last_byte;
						res_q  <= '0;
						unique case (cmd.op)
							OP_PAT_BYTE: begin
								built_q <= 1'b0;
								if (ovf_q) begin
									res_q.status <= ST_FULL;
									state_q      <= S_RESP;
								end else begin
									paddr_q <= child_raddr;
									state_q <= S_PCHK;
								end
							end
							OP_PAT_END: begin
								built_q  <= 1'b0;
								if (ovf_q) begin
									res_q.status <= ST_FULL;
								end
								ovf_q    <= 1'b0;
								cursor_q <= '0;
								state_q  <= S_RESP;
							end
							OP_BUILD: begin
								state_q <= S_BINIT;
							end
							OP_TEXT: begin
								if (!built_q) begin
									res_q.status <= ST_NOT_BUILT;
									state_q      <= S_RESP;
								end else begin
									cur_q   <= scan_node_q;
									state_q <= S_SCHK;
								end
							end
							default: begin
							end
						endcase
					end
				end
				// Pattern byte: follow an existing child, add a node, or drop the pattern when full.
				S_PCHK: begin
					if (rd_child == '0) begin
						if (node_cnt_q == (NW+1)'(MAX_NODES)) begin
							ovf_q        <= 1'b1;
							res_q.status <= ST_FULL;
						end else begin
							node_cnt_q  <= node_cnt_q + (NW+1)'(1);
							cursor_q    <= node_cnt_q[NW-1:0];
							last_addr_q <= paddr_q;
						end
					end else begin
						cursor_q    <= rd_child;
						last_addr_q <= paddr_q;
					end
					state_q <= S_RESP;
				end
				// Text byte: walk failure links until a transition exists or at root.
				S_SCHK: begin
					if (rd_child != '0 || cur_q == '0) begin
						c_q     <= rd_child;
						state_q <= S_SHIT;
					end else begin
						cur_q <= rd_fail;
					end
				end
				S_SHIT: begin
					if (last_q) begin
						res_q.legal       <= !scan_m;
						res_q.string_done <= 1'b1;
						scan_node_q       <= '0;
						match_q           <= 1'b0;
					end else begin
						scan_node_q <= c_q;
						match_q     <= scan_m;
					end
					state_q <= S_RESP;
				end
				// Build: root entry and queue seeded by the memory writes.
				S_BINIT: begin
					head_q  <= '0;
					tail_q  <= (NW+1)'(1);
					state_q <= S_BPOP;
				end
				S_BPOP: begin
					if (head_q == tail_q) begin
						built_q     <= 1'b1;
						scan_node_q <= '0;
						match_q     <= 1'b0;
						state_q     <= S_RESP;
					end else begin
						head_q  <= head_q + (NW+1)'(1);
						state_q <= S_BPOPW;
					end
				end
				S_BPOPW: begin
					p_q     <= queue_rd;
					state_q <= S_BPF;
				end
				S_BPF: begin
					fp_q    <= rd_fail;
					s_q     <= '0;
					state_q <= S_BCRD;
				end
				S_BCRD: begin
					state_q <= S_BCCHK;
				end
				S_BCCHK: begin
					if (rd_child == '0) begin
						if (sym_last) begin
							state_q <= S_BPOP;
						end else begin
							s_q     <= s_q + SW'(1);
							state_q <= S_BCRD;
						end
					end else begin
						c_q  <= rd_child;
						we_q <= child_rd[NW];
						if (p_q == '0) begin
							f_q     <= '0;
							state_q <= S_BHRD;
						end else begin
							t_q     <= fp_q;
							state_q <= S_BTRD;
						end
					end
				end
				S_BTRD: begin
					state_q <= S_BTCHK;
				end
				S_BTCHK: begin
					if (rd_child != '0) begin
						f_q     <= rd_child;
						state_q <= S_BHRD;
					end else if (t_q == '0) begin
						f_q     <= '0;
						state_q <= S_BHRD;
					end else begin
						t_q     <= rd_fail;
						state_q <= S_BTRD;
					end
				end
				S_BHRD: begin
					state_q <= S_BHW;
				end
				S_BHW: begin
					tail_q <= tail_q + (NW+1)'(1);
					if (sym_last) begin
						state_q <= S_BPOP;
					end else begin
						s_q     <= s_q + SW'(1);
						state_q <= S_BCRD;
					end
				end
				// Hand the result to the output register once it is free.
				S_RESP: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_node_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(node_cnt_q != '0) && (node_cnt_q <= (NW+1)'(MAX_NODES)))
		else $error("node count out of range");

	a_cursor_allocated: assert property (@(posedge clk) disable iff (!arst_n)
		(NW+1)'(cursor_q) < node_cnt_q)
		else $error("insert cursor beyond allocated nodes");

	a_scan_allocated: assert property (@(posedge clk) disable iff (!arst_n)
		built_q |-> ((NW+1)'(scan_node_q) < node_cnt_q))
		else $error("scan node beyond allocated nodes");

	a_done_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.string_done) |-> (rsp.status == ST_OK))
		else $error("string result with non-ok status");
`endif

endmodule
